// ===== rtl/bkvm_pkg.sv =====
// bkvm_pkg: shared types and constants of the bounded key-value map
// no dependencies; used by the channel interfaces and bounded_key_value_map

package bkvm_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 16;
   localparam int unsigned OPCODE_WIDTH     = 2;
   localparam int unsigned KEY_WIDTH        = 32;
   localparam int unsigned VALUE_WIDTH      = 32;
   localparam int unsigned COUNT_WIDTH      = 5;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADD    = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   // one slot as held in the table memory
   typedef struct packed {
      logic                          valid;
      logic signed [KEY_WIDTH-1:0]   key;
      logic signed [VALUE_WIDTH-1:0] value;
   } slot_type;

endpackage

// ===== rtl/bkvm_if.sv =====
// bkvm_req_if, bkvm_rsp_if: valid/ready channels for request and reply beats
// depends on bkvm_pkg

interface bkvm_req_if import bkvm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [OPCODE_WIDTH-1:0]       opcode;
   logic signed [KEY_WIDTH-1:0]   key;
   logic signed [VALUE_WIDTH-1:0] new_value;

   modport source (output valid, output opcode, output key, output new_value, input ready);
   modport sink   (input valid, input opcode, input key, input new_value, output ready);
endinterface

interface bkvm_rsp_if import bkvm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic signed [VALUE_WIDTH-1:0] old_value;
   logic                          table_full;
   logic [COUNT_WIDTH-1:0]        entry_count;

   modport source (output valid, output found, output old_value, output table_full,
                   output entry_count, input ready);
   modport sink   (input valid, input found, input old_value, input table_full,
                   input entry_count, output ready);
endinterface

// ===== rtl/bkvm_ram.sv =====
// bkvm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bkvm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bounded_key_value_map.sv =====
// bounded_key_value_map: key-value table of CAPACITY slots held in one ram
// depends on bkvm_pkg, bkvm_req_if, bkvm_rsp_if and bkvm_ram
//
// usage
//  - req_if carries one request beat: opcode (add, search, remove), key and
//    new_value; rsp_if returns exactly one reply beat per request with found,
//    old_value, table_full and entry_count
//  - requests are served one at a time; a request beat is taken only while
//    the sequencer is idle
//  - the first slot read starts when a request is taken; the scan then checks
//    one slot at a time (it stops at the matching slot, at most CAPACITY slots),
//    then write-back loads the registered reply; the single read port of the
//    slot ram keeps the scan to one slot at a time
//  - after reset a clearing pass writes every slot invalid, one slot at a time,
//    and req_if.ready stays low until it ends
//  - the reply sits in an output register, so the next request is taken
//    while a reply waits; if the receiver still stalls when the following
//    reply is due, the sequencer holds in write-back until the beat moves
//  - add of a new key with no free slot stores nothing and flags table_full

module bounded_key_value_map import bkvm_pkg::*; #(
   parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   bkvm_req_if.sink    req_if,
   bkvm_rsp_if.source  rsp_if
);

   localparam int unsigned SLOT_AW    = $clog2(CAPACITY);
   localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
   localparam int unsigned SLOT_BITS  = $bits(slot_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [SLOT_AW-1:0] slot_ff, slot_in;       // slot under check, clear pointer
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // request held for the duration of the scan
   logic [OPCODE_WIDTH-1:0]       op_ff, op_in;
   logic signed [KEY_WIDTH-1:0]   key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;

   // scan results
   logic                          hit_ff, hit_in;
   logic [SLOT_AW-1:0]            hit_slot_ff, hit_slot_in;
   logic signed [VALUE_WIDTH-1:0] old_ff, old_in;
   logic                          free_ok_ff, free_ok_in;
   logic [SLOT_AW-1:0]            free_slot_ff, free_slot_in;

   // reply register
   logic                          rsp_found_ff, rsp_found_in;
   logic signed [VALUE_WIDTH-1:0] rsp_old_ff, rsp_old_in;
   logic                          rsp_full_ff, rsp_full_in;
   logic [COUNT_WIDTH-1:0]        rsp_count_ff, rsp_count_in;

   // ram ports
   logic                 wr_en;
   logic [SLOT_AW-1:0]   wr_addr;
   slot_type             wr_entry;
   logic                 rd_en;
   logic [SLOT_AW-1:0]   rd_addr;
   logic [SLOT_BITS-1:0] rd_data;
   slot_type             rd_entry;

   logic req_accept;
   logic last_slot;
   logic key_match;
   logic is_lookup;
   logic rsp_free;

   bkvm_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry   = slot_type'(rd_data);
   assign req_accept = req_if.valid && req_if.ready;
   assign last_slot  = (slot_ff == SLOT_AW'(CAPACITY - 1));
   // read data always belongs to slot_ff while scanning
   assign key_match  = rd_entry.valid && (rd_entry.key == key_ff);
   assign is_lookup  = (op_ff == OP_ADD) || (op_ff == OP_SEARCH) || (op_ff == OP_REMOVE);
   // reply register can take a new beat this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.old_value   = rsp_old_ff;
   assign rsp_if.table_full  = rsp_full_ff;
   assign rsp_if.entry_count = rsp_count_ff;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      old_in       = old_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      rsp_found_in = rsp_found_ff;
      rsp_old_in   = rsp_old_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_entry     = '0;
      rd_en        = 1'b0;
      // run one slot ahead of the check
      rd_addr      = slot_ff + 1'b1;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // invalidate every slot after reset
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_entry = '0;
            slot_in  = slot_ff + 1'b1;
            if (last_slot) begin
               slot_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_if.opcode;
               key_in     = req_if.key;
               value_in   = req_if.new_value;
               hit_in     = 1'b0;
               old_in     = '0;
               free_ok_in = 1'b0;
               slot_in    = '0;
               rd_en      = 1'b1;
               rd_addr    = '0;
               if ((req_if.opcode == OP_ADD) || (req_if.opcode == OP_SEARCH) ||
                   (req_if.opcode == OP_REMOVE)) begin
                  state_in = ST_SCAN;
               end else begin
                  // unused opcode: straight to the reply
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            // note the lowest free slot on the way
            if (!rd_entry.valid && !free_ok_ff) begin
               free_ok_in   = 1'b1;
               free_slot_in = slot_ff;
            end
            if (key_match) begin
               hit_in      = 1'b1;
               hit_slot_in = slot_ff;
               old_in      = rd_entry.value;
               state_in    = ST_UPDATE;
            end else if (last_slot) begin
               state_in = ST_UPDATE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               rsp_full_in = 1'b0;
               if (is_lookup && (op_ff == OP_ADD)) begin
                  if (hit_ff) begin
                     // overwrite the value in place
                     wr_en          = 1'b1;
                     wr_addr        = hit_slot_ff;
                     wr_entry.valid = 1'b1;
                     wr_entry.key   = key_ff;
                     wr_entry.value = value_ff;
                  end else if (free_ok_ff) begin
                     wr_en          = 1'b1;
                     wr_addr        = free_slot_ff;
                     wr_entry.valid = 1'b1;
                     wr_entry.key   = key_ff;
                     wr_entry.value = value_ff;
                     count_in       = count_ff + 1'b1;
                  end else begin
                     rsp_full_in = 1'b1;
                  end
               end else if (is_lookup && (op_ff == OP_REMOVE) && hit_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = hit_slot_ff;
                  wr_entry.valid = 1'b0;
                  wr_entry.key   = key_ff;
                  wr_entry.value = old_ff;
                  count_in       = count_ff - 1'b1;
               end
               rsp_found_in = hit_ff;
               rsp_old_in   = old_ff;
               rsp_count_in = COUNT_WIDTH'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      old_ff       <= old_in;
      free_ok_ff   <= free_ok_in;
      free_slot_ff <= free_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_old_ff   <= rsp_old_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   // occupancy never passes the slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // the ram is never written while the scan reads it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("slot write during scan");

   // leaving write-back always presents a reply beat
   a_reply_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("write-back finished without reply");

   // a reply never claims both a hit and a full table
   a_hit_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_ff))
      else $error("reply flags found and table_full together");

endmodule
